FILE: src/caption_track_rearranger_assert.svh
// Assertion macros for the caption track rearranger datapath.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef CAPTION_TRACK_REARRANGER_ASSERT_SVH
`define CAPTION_TRACK_REARRANGER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CTR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CTR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: src/ctr_pkg.sv
package ctr_pkg;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int KEY_W      = 12;
  localparam int ROW_W      = 14;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Largest scaled row
  localparam logic [ROW_W-1:0] ROW_MAX = 14'd16383;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // One track as held in the table memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] orig_h;
    logic [ROW_W-1:0] srow;
    logic [ROW_W-1:0] shgt;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

FILE: src/ctr_ram.sv
module ctr_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ctr_ctrl.sv
module ctr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctr_pkg::status_t status,
  output ctr_pkg::cmd_t    cmd
);

  ctr_pkg::state_t state;
  ctr_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence accept, table scan and finish
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ctr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ctr_pkg::ST_SCAN;
        end
      end
      ctr_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ctr_pkg::ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ctr_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ctr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ctr_datapath.sv
`include "caption_track_rearranger_assert.svh"

module ctr_datapath #(
  parameter int MAX_TRACKS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ctr_pkg::cmd_t                     cmd,
  output ctr_pkg::status_t                  status,
  input  logic [ctr_pkg::MODE_W-1:0]        in_mode,
  input  logic [ctr_pkg::IN_DATA_W-1:0]     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ctr_pkg::OUT_DATA_W-1:0]    out_data
);

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int ENT_W = $bits(ctr_pkg::entry_t);
  localparam int KW    = ctr_pkg::KEY_W;
  localparam int RW    = ctr_pkg::ROW_W;

  // Item held for the whole operation
  logic [ctr_pkg::MODE_W-1:0] item_mode;
  logic [KW-1:0]              item_row;
  logic [KW-1:0]              item_rh;
  logic [RW-1:0]              item_ir;
  logic [RW-1:0]              item_ih;

  // Table state
  logic [MAX_TRACKS-1:0] known;
  logic [CNT_W-1:0]      count;

  // Scan pipeline
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  ctr_pkg::entry_t  rd_ent;
  logic [ENT_W-1:0] rd_word;

  // Scan findings
  logic             hit_vld;
  logic [IDX_W-1:0] hit_idx;
  ctr_pkg::entry_t  hit_ent;
  logic             pred_vld;
  logic [IDX_W-1:0] pred_idx;
  ctr_pkg::entry_t  pred_ent;

  // Finish step
  logic             hit_known;
  logic             pred_known;
  logic [KW:0]      adj_sum;
  logic             adjacent;
  logic [RW:0]      chain_sum;
  logic [RW-1:0]    chain_row;
  logic [RW-1:0]    grow_h;
  logic             full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ctr_pkg::entry_t  wr_ent;
  logic             set_known;
  logic             clr_known;
  logic             count_inc;
  logic             clear_all;
  logic [RW-1:0]    res_placed;
  logic             res_found;
  logic             res_moved;
  logic             res_ovf;

  // Output register
  logic [RW-1:0] out_placed;
  logic          out_found;
  logic          out_moved;
  logic          out_ovf;

  assign rd_ent = ctr_pkg::entry_t'(rd_word);

  ctr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.finish & wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (cmd.issue),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_word)
  );

  assign status.scan_done = (rd_idx == count);
  assign status.out_free  = !out_valid || out_ready;

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= in_mode;
      item_row  <= in_data[11:0];
      item_rh   <= in_data[23:12];
      item_ir   <= in_data[37:24];
      item_ih   <= in_data[51:38];
    end
  end

  // Advance the read index and track the data in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.issue;
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
  end

  // Compare each entry against the key: exact hit and nearest smaller key
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_vld  <= 1'b0;
      pred_vld <= 1'b0;
    end else if (cmd.load) begin
      hit_vld  <= 1'b0;
      pred_vld <= 1'b0;
    end else if (cmp_vld) begin
      if (rd_ent.key == item_row) begin
        hit_vld <= 1'b1;
      end
      if (rd_ent.key < item_row && (!pred_vld || rd_ent.key > pred_ent.key)) begin
        pred_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (rd_ent.key == item_row) begin
        hit_idx <= cmp_idx;
        hit_ent <= rd_ent;
      end
      if (rd_ent.key < item_row && (!pred_vld || rd_ent.key > pred_ent.key)) begin
        pred_idx <= cmp_idx;
        pred_ent <= rd_ent;
      end
    end
  end

  // Work out the table update and the result
  always_comb begin
    hit_known  = known[hit_idx];
    pred_known = known[pred_idx];
    adj_sum    = {1'b0, pred_ent.key} + {1'b0, pred_ent.orig_h};
    adjacent   = (adj_sum == {1'b0, item_row});
    chain_sum  = {1'b0, pred_ent.srow} + {1'b0, pred_ent.shgt};
    chain_row  = (chain_sum > {1'b0, ctr_pkg::ROW_MAX}) ? ctr_pkg::ROW_MAX
                                                        : chain_sum[RW-1:0];
    grow_h     = (!hit_known || item_ih > hit_ent.shgt) ? item_ih : hit_ent.shgt;
    full       = (count == CNT_W'(MAX_TRACKS));

    wr_en      = 1'b0;
    wr_addr    = count[IDX_W-1:0];
    wr_ent     = '{key: item_row, orig_h: item_rh, srow: '0, shgt: '0};
    set_known  = 1'b0;
    clr_known  = 1'b0;
    count_inc  = 1'b0;
    clear_all  = 1'b0;
    res_placed = '0;
    res_found  = 1'b0;
    res_moved  = 1'b0;
    res_ovf    = 1'b0;

    case (item_mode)
      ctr_pkg::MODE_ADD: begin
        if (hit_vld) begin
          res_found = 1'b1;
        end else if (full) begin
          res_ovf = 1'b1;
        end else begin
          wr_en     = 1'b1;
          clr_known = 1'b1;
          count_inc = 1'b1;
        end
      end
      ctr_pkg::MODE_PLACE: begin
        res_placed = item_ir;
        if (hit_vld) begin
          res_found     = 1'b1;
          wr_addr       = hit_idx;
          wr_ent.orig_h = hit_ent.orig_h;
          wr_ent.shgt   = grow_h;
          if (!pred_vld || (adjacent && !pred_known)) begin
            // First in its chain: take the image row
            wr_en       = 1'b1;
            set_known   = 1'b1;
            wr_ent.srow = item_ir;
          end else if (adjacent) begin
            // Chain below the predecessor's scaled extent
            wr_en       = 1'b1;
            set_known   = 1'b1;
            res_moved   = 1'b1;
            wr_ent.srow = hit_known ? hit_ent.srow : chain_row;
            res_placed  = wr_ent.srow;
          end
        end
      end
      ctr_pkg::MODE_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Update known bits and track count
  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
      count <= '0;
    end else if (cmd.finish) begin
      if (clear_all) begin
        known <= '0;
        count <= '0;
      end else begin
        if (set_known) begin
          known[wr_addr] <= 1'b1;
        end else if (clr_known) begin
          known[wr_addr] <= 1'b0;
        end
        if (count_inc) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  // Hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_placed <= res_placed;
      out_found  <= res_found;
      out_moved  <= res_moved;
      out_ovf    <= res_ovf;
    end
  end

  assign out_data = {7'd0, out_ovf, out_moved, out_found, out_placed};

  `CTR_ASSERT(a_count_bound, count <= CNT_W'(MAX_TRACKS), "track count beyond table size")
  `CTR_ASSERT(a_no_overwrite, !(cmd.finish && out_valid && !out_ready), "result overwritten")
  `CTR_ASSERT(a_hit_not_pred, !(hit_vld && pred_vld && hit_idx == pred_idx), "hit equals pred")
  `CTR_ASSERT_NEXT(a_place_known, cmd.finish && set_known, known[hit_idx], "track not known")

endmodule

FILE: src/caption_track_rearranger.sv
// Channel  Dir  tvalid/tready  tuser        tdata
// s_axis   in   handshake      mode[1:0]    region_row, region_height, image_row, image_height
// m_axis   out  handshake      -            placed_row, track_found, row_moved, table_overflow
//
// Each item is taken on transfer, then the table is scanned through its single read port
// over the tracks stored (at most MAX_TRACKS), then the table is updated and the result
// register loaded.
// One item is in work at a time; the next is taken once the result is registered.
// The result register waits for m_axis_tready; while it is full, an item may still be
// taken and scanned, and finishes once the result register is free.
// rst is synchronous: it empties the table and drops any pending result.
module caption_track_rearranger #(
  parameter int MAX_TRACKS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] region_row, [23:12] region_height, [37:24] image_row,
  // [51:38] image_height, [55:52] zero
  input  logic [ctr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  logic [ctr_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [13:0] placed_row, [14] track_found, [15] row_moved, [16] table_overflow,
  // [23:17] zero
  output logic [ctr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  ctr_pkg::cmd_t    cmd;
  ctr_pkg::status_t status;

  ctr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctr_datapath #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: dv/tb_caption_track_rearranger.sv
`timescale 1ns / 1ps

module tb_caption_track_rearranger;

  localparam int TRACKS      = 16;
  localparam int RAND_ITEMS  = 1850;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  localparam int MODE_W = ctr_pkg::MODE_W;
  localparam int KEY_W  = ctr_pkg::KEY_W;
  localparam int ROW_W  = ctr_pkg::ROW_W;

  // Unused mode code: no effect, all result fields zero
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  row;
    logic [KEY_W-1:0]  hgt;
    logic [ROW_W-1:0]  img_row;
    logic [ROW_W-1:0]  img_hgt;
    bit                drain;   // wait for every outstanding result before offering
  } caption_req_t;

  typedef struct {
    logic [ROW_W-1:0] placed;
    logic             found;
    logic             moved;
    logic             ovf;
  } placement_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ctr_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]              s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [ctr_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Track table as the predictor sees it
  logic [KEY_W-1:0] key_tab  [TRACKS];
  logic [KEY_W-1:0] oh_tab   [TRACKS];
  logic [ROW_W-1:0] srow_tab [TRACKS];
  logic [ROW_W-1:0] shgt_tab [TRACKS];
  bit               known_tab[TRACKS];
  int               n_tracks;

  caption_req_t caption_reqs[$];
  placement_t   placement_q[$];
  caption_req_t shown_req;
  bit           req_taken;
  bit           hold_rx;
  int           n_total;
  int           n_sent;
  int           n_errors;
  int           idle_cycles;
  int           phase;

  caption_track_rearranger #(
    .MAX_TRACKS(TRACKS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int lookup_track(logic [KEY_W-1:0] key);
    for (int i = 0; i < n_tracks; i++) begin
      if (key_tab[i] == key) return i;
    end
    return -1;
  endfunction

  // Work out the result of one transfer and advance the track table
  function automatic placement_t predict_placement(caption_req_t r);
    placement_t res;
    int         t;
    int         p;
    int         sum;
    bit         adjacent;
    res = '{placed: '0, found: 1'b0, moved: 1'b0, ovf: 1'b0};
    case (r.mode)
      ctr_pkg::MODE_ADD: begin
        if (lookup_track(r.row) >= 0) begin
          res.found = 1'b1;
        end else if (n_tracks >= TRACKS) begin
          res.ovf = 1'b1;
        end else begin
          key_tab[n_tracks]   = r.row;
          oh_tab[n_tracks]    = r.hgt;
          srow_tab[n_tracks]  = '0;
          shgt_tab[n_tracks]  = '0;
          known_tab[n_tracks] = 1'b0;
          n_tracks++;
        end
      end
      ctr_pkg::MODE_PLACE: begin
        res.placed = r.img_row;
        t = lookup_track(r.row);
        if (t >= 0) begin
          res.found = 1'b1;
          // nearest track above: largest key below this one
          p = -1;
          for (int i = 0; i < n_tracks; i++) begin
            if (key_tab[i] < r.row && (p < 0 || key_tab[i] > key_tab[p])) p = i;
          end
          adjacent = (p >= 0) && (int'(key_tab[t]) == int'(key_tab[p]) + int'(oh_tab[p]));
          if (p < 0 || (adjacent && !known_tab[p])) begin
            // take the image row as the track's own
            if (!known_tab[t] || r.img_hgt > shgt_tab[t]) shgt_tab[t] = r.img_hgt;
            srow_tab[t]  = r.img_row;
            known_tab[t] = 1'b1;
          end else if (adjacent) begin
            // chain below the track above, saturating
            if (!known_tab[t]) begin
              sum          = int'(srow_tab[p]) + int'(shgt_tab[p]);
              srow_tab[t]  = (sum > int'(ctr_pkg::ROW_MAX)) ? ctr_pkg::ROW_MAX
                                                            : ROW_W'(sum);
              shgt_tab[t]  = r.img_hgt;
              known_tab[t] = 1'b1;
            end else if (r.img_hgt > shgt_tab[t]) begin
              shgt_tab[t] = r.img_hgt;
            end
            res.placed = srow_tab[t];
            res.moved  = 1'b1;
          end
        end
      end
      ctr_pkg::MODE_CLEAR: begin
        for (int i = 0; i < TRACKS; i++) known_tab[i] = 1'b0;
        n_tracks = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_req(logic [MODE_W-1:0] mode, int row, int hgt, int img_row,
                          int img_hgt, bit drain = 1'b0);
    caption_req_t r;
    r.mode    = mode;
    r.row     = KEY_W'(row);
    r.hgt     = KEY_W'(hgt);
    r.img_row = ROW_W'(img_row);
    r.img_hgt = ROW_W'(img_hgt);
    r.drain   = drain;
    caption_reqs.push_back(r);
  endtask

  // One session: optional clear, a run of mostly adjacent tracks, then placements
  task automatic queue_session(bit drain);
    int keys[$];
    int hgts[$];
    int n;
    int m;
    int j;
    int kv;
    int hv;
    int tmp;
    int key;
    int irow;
    int ihgt;
    if ($urandom_range(0, 4) != 0 || drain)
      push_req(ctr_pkg::MODE_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 16383), $urandom_range(0, 16383), drain);
    n  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
    kv = $urandom_range(0, 3000);
    for (int i = 0; i < n; i++) begin
      hv = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      keys.push_back(kv);
      hgts.push_back(hv);
      kv = ($urandom_range(0, 7) == 0) ? kv + hv + $urandom_range(1, 50) : kv + hv;
      if (kv > 4095) kv = $urandom_range(0, 4095);
    end
    // shuffle insertion order
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(0, n - 1);
      tmp = keys[i]; keys[i] = keys[j]; keys[j] = tmp;
      tmp = hgts[i]; hgts[i] = hgts[j]; hgts[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      push_req(ctr_pkg::MODE_ADD, keys[i], hgts[i], $urandom_range(0, 16383),
               $urandom_range(0, 16383));
      if ($urandom_range(0, 15) == 0)
        push_req(ctr_pkg::MODE_ADD, keys[$urandom_range(0, i)], $urandom_range(0, 4095),
                 $urandom_range(0, 16383), $urandom_range(0, 16383));
    end
    m = $urandom_range(n, 3 * n);
    for (int i = 0; i < m; i++) begin
      key  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                         : keys[$urandom_range(0, n - 1)];
      irow = ($urandom_range(0, 5) == 0) ? $urandom_range(16000, 16383)
                                         : $urandom_range(0, 16383);
      ihgt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 500);
      push_req(ctr_pkg::MODE_PLACE, key, $urandom_range(0, 4095), irow, ihgt);
      if ($urandom_range(0, 40) == 0)
        push_req(MODE_NOP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 16383), $urandom_range(0, 16383));
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    int n_dir;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    hold_rx       = 1'b0;
    req_taken     = 1'b0;
    n_tracks      = 0;
    n_sent        = 0;
    n_errors      = 0;
    idle_cycles   = 0;
    phase         = 0;
    n_total       = 1 << 30;

    // Directed: unused mode, lookups on an empty table, duplicates, every chaining case
    push_req(MODE_NOP, 4095, 4095, 16383, 16383);
    push_req(ctr_pkg::MODE_PLACE, 4095, 0, 16383, 16383);
    push_req(ctr_pkg::MODE_ADD, 0, 100, 0, 0);
    push_req(ctr_pkg::MODE_ADD, 0, 5, 0, 0);
    push_req(ctr_pkg::MODE_ADD, 100, 50, 0, 0);
    push_req(ctr_pkg::MODE_ADD, 150, 4095, 0, 0);
    push_req(ctr_pkg::MODE_ADD, 4095, 0, 0, 0);
    push_req(ctr_pkg::MODE_PLACE, 100, 0, 5, 0);
    push_req(ctr_pkg::MODE_PLACE, 0, 0, 16000, 16383);
    push_req(ctr_pkg::MODE_PLACE, 100, 0, 3, 7);
    push_req(ctr_pkg::MODE_PLACE, 150, 0, 0, 16383);
    push_req(ctr_pkg::MODE_PLACE, 4095, 0, 16383, 1);
    push_req(ctr_pkg::MODE_PLACE, 4094, 0, 77, 77);
    push_req(ctr_pkg::MODE_CLEAR, 0, 0, 0, 0);
    push_req(ctr_pkg::MODE_PLACE, 0, 0, 9, 9);
    push_req(ctr_pkg::MODE_ADD, 10, 20, 0, 0);
    push_req(ctr_pkg::MODE_ADD, 30, 1, 0, 0);
    push_req(ctr_pkg::MODE_PLACE, 10, 0, 16383, 16383);
    push_req(ctr_pkg::MODE_PLACE, 30, 0, 0, 0);
    push_req(ctr_pkg::MODE_PLACE, 10, 0, 1, 2);
    push_req(ctr_pkg::MODE_PLACE, 30, 0, 500, 16383);
    push_req(MODE_NOP, 0, 0, 0, 0);
    push_req(ctr_pkg::MODE_CLEAR, 4095, 4095, 16383, 16383);
    n_dir = caption_reqs.size();

    // Random sessions and single random items, with a few full drains along the way
    queue_session(1'b1);
    while (caption_reqs.size() < n_dir + RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        push_req(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 16383),
                 $urandom_range(0, 16383));
      else
        queue_session($urandom_range(0, 29) == 0);
    end
    n_total = caption_reqs.size();

    repeat (6) @(negedge clk);
    rst = 1'b0;

    while (n_sent < n_total || placement_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && placement_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Long receiver hold-off late in the run so the block backs up into its input
  initial begin
    wait (!rst);
    while (n_sent < (n_total * 5) / 6) @(negedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_rx <= 1'b0;
  end

  always @(negedge clk) begin
    phase <= (n_sent < n_total / 3) ? 0 : (n_sent < (2 * n_total) / 3) ? 1 : 2;
  end

  // Driver: hold the offered transfer until taken, otherwise idle or offer the next
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !req_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (caption_reqs.size() == 0 ||
                   (caption_reqs[0].drain && placement_q.size() != 0) ||
                   $urandom_range(0, 99) < ((phase == 0) ? 32 : (phase == 1) ? 79 : 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        shown_req     <= caption_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= caption_reqs[0].mode;
        s_axis_tdata  <= {4'b0, caption_reqs[0].img_hgt, caption_reqs[0].img_row,
                          caption_reqs[0].hgt, caption_reqs[0].row};
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      m_axis_tready <= !hold_rx &&
                       ($urandom_range(0, 99) >= ((phase == 0) ? 79 : (phase == 1) ? 32 : 0));
    end
  end

  // Input side: predict each accepted transfer
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      placement_q.push_back(predict_placement(shown_req));
      void'(caption_reqs.pop_front());
      n_sent++;
      req_taken = 1'b1;
    end
  end

  // Output side: compare each result with the oldest prediction
  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.placed = m_axis_tdata[13:0];
      got.found  = m_axis_tdata[14];
      got.moved  = m_axis_tdata[15];
      got.ovf    = m_axis_tdata[16];
      if (placement_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: placed %0d found %0d moved %0d ovf %0d",
                   got.placed, got.found, got.moved, got.ovf);
      end else begin
        want = placement_q.pop_front();
        if (got.placed !== want.placed || got.found !== want.found ||
            got.moved !== want.moved || got.ovf !== want.ovf) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: placed %0d/%0d found %0d/%0d moved %0d/%0d ovf %0d/%0d (exp/got)",
                     want.placed, got.placed, want.found, got.found,
                     want.moved, got.moved, want.ovf, got.ovf);
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
